>>> design/segment_fit_allocator_unit_defines.svh
// Shared assertion macros for the segment fit allocator.
`ifndef SEGMENT_FIT_ALLOCATOR_UNIT_DEFINES_SVH
`define SEGMENT_FIT_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define SFA_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("segment fit allocator check failed");

// Next-cycle implication, disabled while reset is low
`define SFA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("segment fit allocator check failed");

`endif

>>> design/sfa_pkg.sv
`default_nettype none

package sfa_pkg;

    // Field widths of the item and result channels
    localparam int MODE_W   = 2;
    localparam int OWNER_W  = 8;
    localparam int SIZE_W   = 17;
    localparam int STATUS_W = 2;
    localparam int START_W  = 16;
    localparam int INDEX_W  = 4;

    // Defaults for the top level parameters
    localparam int MAX_SEGS_DEF  = 16;
    localparam int MEM_WORDS_DEF = 65536;

    // Owner code that marks a free hole
    localparam logic [OWNER_W-1:0] HOLE_ID = 8'd90;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_BEST   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WORST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd3;

    // Result codes
    typedef enum logic [STATUS_W-1:0] {
        RES_DONE   = 2'd0,
        RES_NO_FIT = 2'd1,
        RES_FULL   = 2'd2,
        RES_SIZE   = 2'd3
    } res_code_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DECIDE,
        ST_SHIFT,
        ST_HOLE,
        ST_OWN,
        ST_RESP
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic      capture;
        logic      append_wr;
        logic      scan_start;
        logic      scan_step;
        logic      shift_start;
        logic      shift_step;
        logic      hole_wr;
        logic      own_wr;
        logic      fail;
        res_code_t fail_code;
        logic      load_out;
    } ctl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic size_zero;
        logic is_append;
        logic table_full;
        logic append_ovf;
        logic scan_done;
        logic found;
        logic exact;
        logic shift_done;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> design/sfa_req_if.sv
`default_nettype none

interface sfa_req_if
    import sfa_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [OWNER_W-1:0] owner_id;
    logic [SIZE_W-1:0]  request_size;

    modport source (output valid, output mode, output owner_id, output request_size,
                    input ready);
    modport sink   (input valid, input mode, input owner_id, input request_size,
                    output ready);
endinterface

`default_nettype wire

>>> design/sfa_rsp_if.sv
`default_nettype none

interface sfa_rsp_if
    import sfa_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [START_W-1:0]  seg_start;
    logic [INDEX_W-1:0]  seg_index;
    logic [SIZE_W-1:0]   hole_left;

    modport source (output valid, output status, output seg_start, output seg_index,
                    output hole_left, input ready);
    modport sink   (input valid, input status, input seg_start, input seg_index,
                    input hole_left, output ready);
endinterface

`default_nettype wire

>>> design/segment_fit_allocator_unit.sv
// Flow: a zero-size item or an append is answered straight after the check state.
// A fit scans the table entries in order, and a split then moves the entries after
// the pick up one slot before it writes the remainder hole; the table memory, read
// one entry per cycle, paces the scan and the shift. One item is in work at a time;
// the next item is accepted only after the last result is loaded into the output register.
// Reset clears the segment count and append point; table contents stay undefined.
`default_nettype none

module segment_fit_allocator_unit
    import sfa_pkg::*;
#(
    parameter int MAX_SEGS  = MAX_SEGS_DEF,
    parameter int MEM_WORDS = MEM_WORDS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    sfa_req_if.sink   req,
    sfa_rsp_if.source rsp
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    sfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sfa_datapath #(
        .MAX_SEGS  (MAX_SEGS),
        .MEM_WORDS (MEM_WORDS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .mode         (req.mode),
        .owner_id     (req.owner_id),
        .request_size (req.request_size),
        .rsp_ready    (rsp.ready),
        .rsp_valid    (rsp.valid),
        .status       (rsp.status),
        .seg_start    (rsp.seg_start),
        .seg_index    (rsp.seg_index),
        .hole_left    (rsp.hole_left)
    );

endmodule

`default_nettype wire

>>> design/sfa_ram.sv
`default_nettype none

module sfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> design/sfa_ctrl.sv
`default_nettype none

module sfa_ctrl
    import sfa_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire dp_stat_t stat,
    output ctl_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.size_zero || stat.is_append)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                priority if (!stat.found)
                begin
                    state_next = ST_RESP;
                end
                else if (stat.exact)
                begin
                    state_next = ST_OWN;
                end
                else if (stat.table_full)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (stat.shift_done)
                begin
                    state_next = ST_HOLE;
                end
            end
            ST_HOLE:
            begin
                state_next = ST_OWN;
            end
            ST_OWN:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd       = '0;
        cmd.fail_code = RES_DONE;
        req_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            ST_CHECK:
            begin
                priority if (stat.size_zero)
                begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = RES_SIZE;
                end
                else if (stat.is_append && stat.table_full)
                begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = RES_FULL;
                end
                else if (stat.is_append && stat.append_ovf)
                begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = RES_SIZE;
                end
                else if (stat.is_append)
                begin
                    cmd.append_wr = 1'b1;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            ST_DECIDE:
            begin
                priority if (!stat.found)
                begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = RES_NO_FIT;
                end
                else if (stat.exact)
                begin
                    cmd.fail = 1'b0;
                end
                else if (stat.table_full)
                begin
                    cmd.fail      = 1'b1;
                    cmd.fail_code = RES_FULL;
                end
                else
                begin
                    cmd.shift_start = 1'b1;
                end
            end
            ST_SHIFT:
            begin
                cmd.shift_step = 1'b1;
            end
            ST_HOLE:
            begin
                cmd.hole_wr = 1'b1;
            end
            ST_OWN:
            begin
                cmd.own_wr = 1'b1;
            end
            ST_RESP:
            begin
                cmd.load_out = stat.out_free;
            end
            default:
            begin
                cmd.fail = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/sfa_datapath.sv
`default_nettype none
`include "segment_fit_allocator_unit_defines.svh"

module sfa_datapath
    import sfa_pkg::*;
#(
    parameter int MAX_SEGS  = MAX_SEGS_DEF,
    parameter int MEM_WORDS = MEM_WORDS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ctl_cmd_t            cmd,
    output dp_stat_t                 stat,
    input  wire logic [MODE_W-1:0]   mode,
    input  wire logic [OWNER_W-1:0]  owner_id,
    input  wire logic [SIZE_W-1:0]   request_size,
    input  wire logic                rsp_ready,
    output logic                     rsp_valid,
    output logic [STATUS_W-1:0]      status,
    output logic [START_W-1:0]       seg_start,
    output logic [INDEX_W-1:0]       seg_index,
    output logic [SIZE_W-1:0]        hole_left
);

    localparam int AW   = $clog2(MAX_SEGS);
    localparam int CW   = $clog2(MAX_SEGS + 1);
    localparam int BW   = $clog2(MEM_WORDS + 1);
    localparam int SUMW = ((BW > SIZE_W) ? BW : SIZE_W) + 1;
    localparam int EW   = OWNER_W + BW + SIZE_W;

    // Captured item
    logic [MODE_W-1:0]  mode_reg;
    logic [OWNER_W-1:0] owner_reg;
    logic [SIZE_W-1:0]  size_reg;

    // Table bookkeeping
    logic [CW-1:0] count_reg,     count_next;
    logic [BW-1:0] append_pt_reg, append_pt_next;

    // Scan and shift sequencing
    logic [CW-1:0]     ptr_reg,       ptr_next;
    logic              rd_vld_reg,    rd_vld_next;
    logic [CW-1:0]     rd_idx_reg,    rd_idx_next;
    logic              found_reg,     found_next;
    logic [AW-1:0]     pick_reg,      pick_next;
    logic [SIZE_W-1:0] best_reg,      best_next;
    logic [BW-1:0]     pick_base_reg, pick_base_next;

    // Pending result and output register
    res_code_t          res_code_reg,  res_code_next;
    logic [START_W-1:0] res_start_reg, res_start_next;
    logic [INDEX_W-1:0] res_index_reg, res_index_next;
    logic [SIZE_W-1:0]  res_left_reg,  res_left_next;
    logic               out_valid_reg, out_valid_next;
    res_code_t          out_code_reg;
    logic [START_W-1:0] out_start_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic [SIZE_W-1:0]  out_left_reg;

    // Table memory
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [EW-1:0] ram_rdata;

    // Entry fields and helpers
    logic [OWNER_W-1:0] e_owner;
    logic [BW-1:0]      e_base;
    logic [SIZE_W-1:0]  e_len;
    logic               e_fits;
    logic [SIZE_W-1:0]  e_diff;
    logic               e_take;
    logic               first_stop;
    logic               issue;
    logic [CW-1:0]      pick_ext;
    logic [SUMW-1:0]    append_sum;
    logic [SUMW-1:0]    split_sum;
    logic [BW+START_W-1:0] append_base_ext;
    logic [BW+START_W-1:0] pick_base_ext;
    logic [AW+INDEX_W-1:0] count_idx_ext;
    logic [AW+INDEX_W-1:0] pick_idx_ext;

    sfa_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SEGS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Split the read entry
    assign e_owner = ram_rdata[EW-1 -: OWNER_W];
    assign e_base  = ram_rdata[SIZE_W +: BW];
    assign e_len   = ram_rdata[SIZE_W-1:0];
    assign e_fits  = (e_owner == HOLE_ID) && (e_len >= size_reg);
    assign e_diff  = e_len - size_reg;
    assign e_take  = e_fits && (!found_reg
                     || ((mode_reg == MODE_BEST) && (e_diff < best_reg))
                     || ((mode_reg == MODE_WORST) && (e_diff > best_reg)));

    assign first_stop = (mode_reg == MODE_FIRST) && found_reg;
    assign pick_ext   = CW'(pick_reg);
    assign append_sum = SUMW'(append_pt_reg) + SUMW'(size_reg);
    assign split_sum  = SUMW'(pick_base_reg) + SUMW'(size_reg);

    // Fit output fields to the fixed result widths
    assign append_base_ext = {{START_W{1'b0}}, append_pt_reg};
    assign pick_base_ext   = {{START_W{1'b0}}, pick_base_reg};
    assign count_idx_ext   = {{INDEX_W{1'b0}}, count_reg[AW-1:0]};
    assign pick_idx_ext    = {{INDEX_W{1'b0}}, pick_reg};

    // Read issue: upward during scan, downward during shift
    always_comb
    begin
        issue = 1'b0;
        if (cmd.scan_step)
        begin
            issue = (ptr_reg < count_reg) && !first_stop;
        end
        else if (cmd.shift_step)
        begin
            issue = ptr_reg > pick_ext;
        end
    end

    assign ram_raddr = ptr_reg[AW-1:0];

    // Table write port
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pick_reg;
        ram_wdata = {owner_reg, pick_base_reg, size_reg};
        priority if (cmd.append_wr)
        begin
            ram_we    = 1'b1;
            ram_waddr = count_reg[AW-1:0];
            ram_wdata = {owner_reg, append_pt_reg, size_reg};
        end
        else if (cmd.shift_step && rd_vld_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = AW'(rd_idx_reg + 1'b1);
            ram_wdata = ram_rdata;
        end
        else if (cmd.hole_wr)
        begin
            ram_we    = 1'b1;
            ram_waddr = AW'(pick_ext + 1'b1);
            ram_wdata = {HOLE_ID, BW'(split_sum), best_reg};
        end
        else if (cmd.own_wr)
        begin
            ram_we = 1'b1;
        end
    end

    // Sequencer and search registers
    always_comb
    begin
        ptr_next       = ptr_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = ptr_reg;
        found_next     = found_reg;
        pick_next      = pick_reg;
        best_next      = best_reg;
        pick_base_next = pick_base_reg;
        count_next     = count_reg;
        append_pt_next = append_pt_reg;
        if (cmd.scan_start)
        begin
            ptr_next   = '0;
            found_next = 1'b0;
        end
        if (cmd.shift_start)
        begin
            ptr_next = CW'(count_reg - 1'b1);
        end
        if (cmd.scan_step)
        begin
            rd_vld_next = issue;
            if (issue)
            begin
                ptr_next = CW'(ptr_reg + 1'b1);
            end
            if (rd_vld_reg && e_take)
            begin
                found_next     = 1'b1;
                pick_next      = rd_idx_reg[AW-1:0];
                best_next      = e_diff;
                pick_base_next = e_base;
            end
        end
        if (cmd.shift_step)
        begin
            rd_vld_next = issue;
            if (issue)
            begin
                ptr_next = CW'(ptr_reg - 1'b1);
            end
        end
        if (cmd.append_wr)
        begin
            count_next     = CW'(count_reg + 1'b1);
            append_pt_next = BW'(append_sum);
        end
        if (cmd.own_wr && (best_reg != '0))
        begin
            count_next = CW'(count_reg + 1'b1);
        end
    end

    // Pending result and output register
    always_comb
    begin
        res_code_next  = res_code_reg;
        res_start_next = res_start_reg;
        res_index_next = res_index_reg;
        res_left_next  = res_left_reg;
        out_valid_next = out_valid_reg;
        priority if (cmd.fail)
        begin
            res_code_next  = cmd.fail_code;
            res_start_next = '0;
            res_index_next = '0;
            res_left_next  = '0;
        end
        else if (cmd.append_wr)
        begin
            res_code_next  = RES_DONE;
            res_start_next = append_base_ext[START_W-1:0];
            res_index_next = count_idx_ext[INDEX_W-1:0];
            res_left_next  = '0;
        end
        else if (cmd.own_wr)
        begin
            res_code_next  = RES_DONE;
            res_start_next = pick_base_ext[START_W-1:0];
            res_index_next = pick_idx_ext[INDEX_W-1:0];
            res_left_next  = best_reg;
        end
        else
        begin
            res_code_next = res_code_reg;
        end
        if (rsp_valid && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            append_pt_reg <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            append_pt_reg <= append_pt_next;
            rd_vld_reg    <= rd_vld_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg  <= mode;
            owner_reg <= owner_id;
            size_reg  <= request_size;
        end
        ptr_reg       <= ptr_next;
        rd_idx_reg    <= rd_idx_next;
        pick_reg      <= pick_next;
        best_reg      <= best_next;
        pick_base_reg <= pick_base_next;
        res_code_reg  <= res_code_next;
        res_start_reg <= res_start_next;
        res_index_reg <= res_index_next;
        res_left_reg  <= res_left_next;
        if (cmd.load_out)
        begin
            out_code_reg  <= res_code_reg;
            out_start_reg <= res_start_reg;
            out_index_reg <= res_index_reg;
            out_left_reg  <= res_left_reg;
        end
    end

    // Status to controller
    always_comb
    begin
        stat            = '0;
        stat.size_zero  = (size_reg == '0);
        stat.is_append  = (mode_reg == MODE_APPEND);
        stat.table_full = (count_reg >= CW'(MAX_SEGS));
        stat.append_ovf = (append_sum > SUMW'(MEM_WORDS));
        stat.scan_done  = first_stop || ((ptr_reg >= count_reg) && !rd_vld_reg);
        stat.found      = found_reg;
        stat.exact      = (best_reg == '0);
        stat.shift_done = (ptr_reg == pick_ext) && !rd_vld_reg;
        stat.out_free   = !out_valid_reg || rsp_ready;
    end

    assign rsp_valid = out_valid_reg;
    assign status    = out_code_reg;
    assign seg_start = out_start_reg;
    assign seg_index = out_index_reg;
    assign hole_left = out_left_reg;

    `SFA_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(MAX_SEGS))
    `SFA_ASSERT_NEXT(a_split_grows, clk, rst_n, cmd.own_wr && !stat.exact, count_reg == CW'($past(count_reg) + 1'b1))
    `SFA_ASSERT_IMPL(a_shift_range, clk, rst_n, cmd.shift_step && rd_vld_reg, (rd_idx_reg < count_reg) && (rd_idx_reg > pick_ext))
    `SFA_ASSERT_IMPL(a_append_up, clk, rst_n, !$stable(append_pt_reg), append_pt_reg > $past(append_pt_reg))

endmodule

`default_nettype wire

>>> dv/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sfa_pkg::*;

    localparam int TABLE_DEPTH  = MAX_SEGS_DEF;
    localparam int MEM_SPAN     = MEM_WORDS_DEF;
    localparam int RANDOM_ITEMS = 1030;
    localparam int QUIET_ITEMS  = 150;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 400000;

    // One expected response of the allocator
    typedef struct {
        res_code_t           status;
        logic [START_W-1:0]  start;
        logic [INDEX_W-1:0]  index;
        logic [SIZE_W-1:0]   left;
    } grant_t;

    // Shadow segment table: predicts each grant and checks the ones that come back
    class seg_alloc_tracker;
        logic [OWNER_W-1:0] owner_tab [TABLE_DEPTH];
        logic [START_W-1:0] base_tab [TABLE_DEPTH];
        logic [SIZE_W-1:0]  len_tab [TABLE_DEPTH];
        int                 used;
        int                 next_addr;
        grant_t             due_grants [$];
        int                 mismatches;

        function new();
            used       = 0;
            next_addr  = 0;
            mismatches = 0;
        endfunction

        // Work out the grant for one accepted request and update the table
        function void note_request(logic [MODE_W-1:0] m, logic [OWNER_W-1:0] who,
                                   logic [SIZE_W-1:0] words);
            grant_t g;
            int     k;
            int     pick;
            int     slack;
            int     diff;
            bit     hit;

            g.status = RES_DONE;
            g.start  = '0;
            g.index  = '0;
            g.left   = '0;
            pick     = 0;
            slack    = 0;
            hit      = 1'b0;

            if (words == 0) begin
                g.status = RES_SIZE;
            end
            else if (m == MODE_APPEND) begin
                // Append after the last segment
                if (used >= TABLE_DEPTH)
                    g.status = RES_FULL;
                else if (next_addr + int'(words) > MEM_SPAN)
                    g.status = RES_SIZE;
                else
                begin
                    owner_tab[used] = who;
                    base_tab[used]  = START_W'(next_addr);
                    len_tab[used]   = words;
                    g.start         = START_W'(next_addr);
                    g.index         = INDEX_W'(used);
                    used++;
                    next_addr += int'(words);
                end
            end
            else
            begin
                // Scan the holes; ties keep the earliest one
                for (k = 0; k < used; k++) begin
                    if (owner_tab[k] != HOLE_ID || len_tab[k] < words)
                        continue;
                    diff = int'(len_tab[k]) - int'(words);
                    if (!hit) begin
                        hit   = 1'b1;
                        pick  = k;
                        slack = diff;
                        if (m == MODE_FIRST)
                            break;
                    end
                    else if ((m == MODE_BEST && diff < slack) ||
                             (m == MODE_WORST && diff > slack)) begin
                        pick  = k;
                        slack = diff;
                    end
                end

                if (!hit)
                    g.status = RES_NO_FIT;
                else if (slack != 0 && used >= TABLE_DEPTH)
                    g.status = RES_FULL;
                else
                begin
                    // Split: open a slot after the pick for the remainder hole
                    if (slack != 0) begin
                        for (k = used; k > pick + 1; k--) begin
                            owner_tab[k] = owner_tab[k-1];
                            base_tab[k]  = base_tab[k-1];
                            len_tab[k]   = len_tab[k-1];
                        end
                        owner_tab[pick+1] = HOLE_ID;
                        base_tab[pick+1]  = base_tab[pick] + START_W'(words);
                        len_tab[pick+1]   = SIZE_W'(slack);
                        len_tab[pick]     = words;
                        used++;
                    end
                    owner_tab[pick] = who;
                    g.start         = base_tab[pick];
                    g.index         = INDEX_W'(pick);
                    g.left          = SIZE_W'(slack);
                end
            end
            due_grants.push_back(g);
        endfunction

        // Compare one accepted response with the oldest expected grant
        function void check_grant(logic [STATUS_W-1:0] st, logic [START_W-1:0] start,
                                  logic [INDEX_W-1:0] idx, logic [SIZE_W-1:0] left);
            grant_t g;

            if (due_grants.size() == 0) begin
                $display("%0t: response with none expected: status %0d start %0d",
                         $time, st, start);
                mismatches++;
                return;
            end
            g = due_grants.pop_front();
            if (st !== g.status) begin
                $display("%0t: status expected %0d actual %0d", $time, g.status, st);
                mismatches++;
            end
            if (start !== g.start) begin
                $display("%0t: seg_start expected %0d actual %0d", $time, g.start, start);
                mismatches++;
            end
            if (idx !== g.index) begin
                $display("%0t: seg_index expected %0d actual %0d", $time, g.index, idx);
                mismatches++;
            end
            if (left !== g.left) begin
                $display("%0t: hole_left expected %0d actual %0d", $time, g.left, left);
                mismatches++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   quiet = 1'b0;
    int   cycle_count = 0;

    seg_alloc_tracker seg_table = new();

    sfa_req_if req_ch ();
    sfa_rsp_if rsp_ch ();

    segment_fit_allocator_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // 50 MHz clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL segment_fit_allocator_unit");
            $finish;
        end
    end

    // Offer one request item and hold it until the allocator takes it
    task automatic send_request(input logic [MODE_W-1:0] m, input logic [OWNER_W-1:0] who,
                                input logic [SIZE_W-1:0] words);
        // idle the request side for a short burst now and then
        if (!quiet && $urandom_range(0, 4) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= m;
        req_ch.owner_id     <= who;
        req_ch.request_size <= words;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        seg_table.note_request(m, who, words);
    endtask

    // Response side: check each accepted item, stall in random bursts
    initial
    begin : response_side
        int stall;

        stall = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
                seg_table.check_grant(rsp_ch.status, rsp_ch.seg_start, rsp_ch.seg_index,
                                      rsp_ch.hole_left);
            if (stall == 0 && !quiet && $urandom_range(0, 5) == 0)
                stall = $urandom_range(1, 4);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Request side: reset, directed items, random items, drain
    initial
    begin : request_side
        int                 n;
        int                 r;
        int                 h;
        logic [MODE_W-1:0]  m;
        logic [OWNER_W-1:0] who;
        logic [SIZE_W-1:0]  words;
        logic [SIZE_W-1:0]  free_lens [$];

        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.mode         <= MODE_BEST;
        req_ch.owner_id     <= '0;
        req_ch.request_size <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Empty table, zero sizes
        send_request(MODE_BEST, 8'd7, 17'd5);
        send_request(MODE_APPEND, 8'd0, 17'd0);
        send_request(MODE_WORST, 8'd9, 17'd0);
        // Load a layout of owned segments and holes
        send_request(MODE_APPEND, 8'd1, 17'd100);
        send_request(MODE_APPEND, HOLE_ID, 17'd300);
        send_request(MODE_APPEND, 8'd2, 17'd50);
        send_request(MODE_APPEND, HOLE_ID, 17'd200);
        send_request(MODE_APPEND, 8'd3, 17'd10);
        send_request(MODE_APPEND, HOLE_ID, 17'd300);
        send_request(MODE_APPEND, 8'd255, 17'd1);
        // Append past the end of memory
        send_request(MODE_APPEND, 8'd0, 17'd65536);
        // Worst fit with a tie, then exact fits in best and first modes
        send_request(MODE_WORST, 8'd20, 17'd50);
        send_request(MODE_BEST, 8'd21, 17'd200);
        send_request(MODE_FIRST, 8'd22, 17'd250);
        send_request(MODE_BEST, 8'd23, 17'd300);
        send_request(MODE_FIRST, 8'd24, 17'd65536);
        // Equal holes, a hole-owner requester, splits
        send_request(MODE_APPEND, HOLE_ID, 17'd400);
        send_request(MODE_APPEND, HOLE_ID, 17'd400);
        send_request(MODE_BEST, HOLE_ID, 17'd100);
        send_request(MODE_FIRST, 8'd25, 17'd1);
        send_request(MODE_WORST, 8'hAA, 17'd399);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            quiet = (n >= RANDOM_ITEMS - QUIET_ITEMS);

            // hold off until every outstanding grant has come back
            if (n % 250 == 125) begin
                req_ch.valid <= 1'b0;
                do
                    @(posedge clk);
                while (seg_table.due_grants.size() != 0);
            end

            // collect current hole lengths so requests can aim at them
            free_lens.delete();
            for (h = 0; h < seg_table.used; h++)
                if (seg_table.owner_tab[h] == HOLE_ID)
                    free_lens.push_back(seg_table.len_tab[h]);

            r = $urandom_range(0, 99);
            if (r < 6) begin
                // noise: any mode, zero or arbitrary size
                m     = MODE_W'($urandom_range(0, 3));
                who   = OWNER_W'($urandom_range(0, 255));
                words = $urandom_range(0, 1) ? '0 : SIZE_W'($urandom_range(0, MEM_SPAN));
            end
            else if (r < (seg_table.used < TABLE_DEPTH ? 35 : 12)) begin
                // append: mostly small, sometimes an exact fill or an overflow
                m = MODE_APPEND;
                if (free_lens.size() < 3 || $urandom_range(0, 1))
                    who = HOLE_ID;
                else
                    who = OWNER_W'($urandom_range(0, 255));
                if (seg_table.used == TABLE_DEPTH - 1 && $urandom_range(0, 2) == 0)
                    words = SIZE_W'(MEM_SPAN - seg_table.next_addr);
                else if (seg_table.next_addr > 0 && seg_table.next_addr < MEM_SPAN &&
                         $urandom_range(0, 9) == 0)
                    words = SIZE_W'($urandom_range(MEM_SPAN - seg_table.next_addr + 1,
                                                   MEM_SPAN));
                else
                    words = SIZE_W'($urandom_range(1, 3000));
            end
            else
            begin
                // fit request: keep a few holes alive by mostly asking as a hole owner
                m = MODE_W'($urandom_range(0, 2));
                if (free_lens.size() <= 3 || $urandom_range(0, 6) != 0)
                    who = HOLE_ID;
                else
                    who = OWNER_W'($urandom_range(0, 255));
                r = $urandom_range(0, 99);
                if (free_lens.size() == 0 || r < 15)
                    words = SIZE_W'($urandom_range(1, 4000));
                else if (r < 20)
                    words = SIZE_W'($urandom_range(1, MEM_SPAN));
                else
                begin
                    h = free_lens[$urandom_range(0, free_lens.size() - 1)];
                    if (r < 70)
                        words = SIZE_W'(h);
                    else if (r < 90)
                        words = SIZE_W'($urandom_range(1, h));
                    else
                        words = SIZE_W'((h < MEM_SPAN) ? h + 1 : h);
                end
            end
            send_request(m, who, words);
        end
        req_ch.valid <= 1'b0;

        // Drain outstanding grants, then let the pipeline settle
        while (seg_table.due_grants.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (seg_table.mismatches == 0 && seg_table.due_grants.size() == 0)
            $display("PASS segment_fit_allocator_unit");
        else
            $display("FAIL segment_fit_allocator_unit");
        $finish;
    end

endmodule

`default_nettype wire
